// ----- hdl/rpps_pkg.sv -----
package rpps_pkg;

	// Field widths
	localparam int ANG_W = 18;
	localparam int OUT_W = 15;
	localparam int GAIN_W = 16;
	localparam int TMR_W = 8;
	localparam int DIFF_W = 20;
	localparam int ERR_W = 17;
	localparam int DE_W = 18;
	localparam int SPD_W = 19;
	localparam int LIM_W = 16;

	// Shared multiplier: signed A times signed B. A covers a setpoint step times the
	// largest tick rate (1000), B covers the ramp reciprocal.
	localparam int MA_W = 29;
	localparam int MB_W = 32;
	localparam int PROD_W = 61;

	// Rounded term widths and the final sum
	localparam int DT_W = 27;
	localparam int KT_W = 38;
	localparam int SUM_W = 40;

	// Ramp division by a constant: x * ceil(2^RDIV_SH / RAMP_TICKS) >> RDIV_SH
	localparam int RDIV_SH = 30;
	localparam int RX_W = 22;
	localparam int RECIP_W = 31;
	localparam int Q_W = 14;

	localparam logic [4:0] RND_8 = 5'd8;
	localparam logic [4:0] RND_16 = 5'd16;

	// Default parameters
	localparam int TICK_RATE_DEF = 500;
	localparam int RAMP_TICKS_DEF = 100;

	// Angle constants in 1/256 degree
	localparam logic signed [DIFF_W-1:0] FULL_TURN = 20'sd92160;
	localparam logic signed [DIFF_W-1:0] HALF_TURN = 20'sd46080;
	localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -20'sd46080;
	localparam logic signed [DIFF_W-1:0] FILTER_WRAP = 20'sd76800;
	localparam logic signed [DIFF_W-1:0] NEG_FILTER_WRAP = -20'sd76800;
	localparam logic signed [DIFF_W-1:0] FILTER_WIN = 20'sd2560;
	localparam logic signed [DIFF_W-1:0] NEG_FILTER_WIN = -20'sd2560;

	localparam logic signed [LIM_W-1:0] TRACK_LIMIT = 16'sd15360;
	localparam logic signed [LIM_W-1:0] POINT_LIMIT = 16'sd7680;
	localparam logic [GAIN_W-1:0] POINT_GAIN = 16'd1280;
	localparam int SOFT_THRESH = 655360;

	// Register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_PROP = 3'd1;
	localparam logic [2:0] REG_INTEG = 3'd2;
	localparam logic [2:0] REG_DERIV = 3'd3;
	localparam logic [2:0] REG_FFWD = 3'd4;

	localparam logic MODE_TRACK = 1'b0;
	localparam logic MODE_POINT = 1'b1;

	typedef struct packed {
		logic mode;
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integral_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [GAIN_W-1:0] feedfwd_gain;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TGT, S_ERR, S_P, S_I, S_CMP, S_D, S_KT, S_K, S_RS, S_RQ, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		STEP_NONE, STEP_TGT, STEP_ERR, STEP_P, STEP_I, STEP_CMP, STEP_D, STEP_KT,
		STEP_K, STEP_RS, STEP_RQ
	} step_t;

	typedef struct packed {
		logic load;
		step_t step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	// Rounds x / 2^n half away from zero.
	function automatic logic signed [PROD_W-1:0] rnd_shift(
		input logic signed [PROD_W-1:0] x, input logic [4:0] n);
		logic signed [PROD_W-1:0] m;
		logic signed [PROD_W-1:0] r;
		m = (x < 0) ? -x : x;
		r = (m + (PROD_W'(1) << (n - 5'd1))) >> n;
		return (x < 0) ? -r : r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(
		input logic signed [PROD_W-1:0] x, input logic signed [LIM_W-1:0] lim);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(lim);
		lo = -hi;
		if (x > hi)
			return OUT_W'(hi);
		if (x < lo)
			return OUT_W'(lo);
		return OUT_W'(x);
	endfunction

	// Reduces an angle difference into (-180, +180] degrees. Inputs stay within
	// three turns, so three conditional corrections suffice.
	function automatic logic signed [ERR_W-1:0] wrap_turn(input logic signed [DIFF_W-1:0] x);
		logic signed [DIFF_W-1:0] r;
		r = x;
		for (int k = 0; k < 3; k++) begin
			if (r > HALF_TURN)
				r = r - FULL_TURN;
			else if (r <= NEG_HALF_TURN)
				r = r + FULL_TURN;
		end
		return ERR_W'(r);
	endfunction

endpackage

// ----- hdl/rpps_ifs.sv -----
interface rpps_in_if;
	logic valid;
	logic ready;
	logic signed [rpps_pkg::ANG_W-1:0] setpoint;
	logic signed [rpps_pkg::ANG_W-1:0] lookahead_target;
	logic signed [rpps_pkg::ANG_W-1:0] measured;

	modport source (output valid, setpoint, lookahead_target, measured, input ready);
	modport sink (input valid, setpoint, lookahead_target, measured, output ready);
endinterface

interface rpps_out_if;
	logic valid;
	logic ready;
	logic signed [rpps_pkg::OUT_W-1:0] drive;
	logic signed [rpps_pkg::OUT_W-1:0] p_term;
	logic signed [rpps_pkg::OUT_W-1:0] i_term;
	logic signed [rpps_pkg::ANG_W-1:0] target_used;

	modport source (output valid, drive, p_term, i_term, target_used, input ready);
	modport sink (input valid, drive, p_term, i_term, target_used, output ready);
endinterface

// ----- hdl/rpps_ctrl.sv -----
module rpps_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rpps_pkg::stat_t stat,
	output rpps_pkg::cmd_t cmd
);

	rpps_pkg::state_t state_q;
	rpps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.step = rpps_pkg::STEP_NONE;
		cmd.commit = 1'b0;
		case (state_q)
			rpps_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rpps_pkg::S_TGT;
				end
			end
			rpps_pkg::S_TGT: begin
				cmd.step = rpps_pkg::STEP_TGT;
				state_d = rpps_pkg::S_ERR;
			end
			rpps_pkg::S_ERR: begin
				cmd.step = rpps_pkg::STEP_ERR;
				state_d = rpps_pkg::S_P;
			end
			rpps_pkg::S_P: begin
				cmd.step = rpps_pkg::STEP_P;
				state_d = rpps_pkg::S_I;
			end
			rpps_pkg::S_I: begin
				cmd.step = rpps_pkg::STEP_I;
				state_d = rpps_pkg::S_CMP;
			end
			rpps_pkg::S_CMP: begin
				cmd.step = rpps_pkg::STEP_CMP;
				state_d = rpps_pkg::S_D;
			end
			rpps_pkg::S_D: begin
				cmd.step = rpps_pkg::STEP_D;
				state_d = rpps_pkg::S_KT;
			end
			rpps_pkg::S_KT: begin
				cmd.step = rpps_pkg::STEP_KT;
				state_d = rpps_pkg::S_K;
			end
			rpps_pkg::S_K: begin
				cmd.step = rpps_pkg::STEP_K;
				state_d = rpps_pkg::S_RS;
			end
			rpps_pkg::S_RS: begin
				cmd.step = rpps_pkg::STEP_RS;
				state_d = rpps_pkg::S_RQ;
			end
			rpps_pkg::S_RQ: begin
				cmd.step = rpps_pkg::STEP_RQ;
				state_d = rpps_pkg::S_FIN;
			end
			rpps_pkg::S_FIN: begin
				// Hold here until the output register can take the result.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = rpps_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rpps_pkg::S_IDLE;
			end
		endcase
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == rpps_pkg::S_TGT)
		else $error("accepted item did not start the sequence");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (state_q == rpps_pkg::S_FIN) && stat.out_free)
		else $error("commit without a free output register");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rpps_pkg::S_IDLE && state_q != rpps_pkg::S_FIN)
		|=> state_q != $past(state_q))
		else $error("sequencer stalled inside an item");

endmodule

// ----- hdl/rpps_dp.sv -----
module rpps_dp #(
	parameter int TICK_RATE = rpps_pkg::TICK_RATE_DEF,
	parameter int RAMP_TICKS = rpps_pkg::RAMP_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  rpps_pkg::cfg_t cfg,
	input  rpps_pkg::cmd_t cmd,
	output rpps_pkg::stat_t stat,
	input  logic signed [rpps_pkg::ANG_W-1:0] setpoint,
	input  logic signed [rpps_pkg::ANG_W-1:0] lookahead_target,
	input  logic signed [rpps_pkg::ANG_W-1:0] measured,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [rpps_pkg::OUT_W-1:0] drive,
	output logic signed [rpps_pkg::OUT_W-1:0] p_term,
	output logic signed [rpps_pkg::OUT_W-1:0] i_term,
	output logic signed [rpps_pkg::ANG_W-1:0] target_used
);

	localparam int AW = rpps_pkg::ANG_W;
	localparam int OW = rpps_pkg::OUT_W;
	localparam int GW = rpps_pkg::GAIN_W;
	localparam int TW = rpps_pkg::TMR_W;
	localparam int DW = rpps_pkg::DIFF_W;
	localparam int EW = rpps_pkg::ERR_W;
	localparam int DEW = rpps_pkg::DE_W;
	localparam int SW = rpps_pkg::SPD_W;
	localparam int MA = rpps_pkg::MA_W;
	localparam int MB = rpps_pkg::MB_W;
	localparam int PW = rpps_pkg::PROD_W;
	localparam int DTW = rpps_pkg::DT_W;
	localparam int KTW = rpps_pkg::KT_W;
	localparam int SUMW = rpps_pkg::SUM_W;
	localparam int RXW = rpps_pkg::RX_W;
	localparam int RSH = rpps_pkg::RDIV_SH;
	localparam int QW = rpps_pkg::Q_W;
	localparam int RCW = rpps_pkg::RECIP_W;
	localparam logic [RCW-1:0] RECIP =
		RCW'(((64'd1 << rpps_pkg::RDIV_SH) + 64'(RAMP_TICKS) - 64'd1) / 64'(RAMP_TICKS));
	localparam logic [RXW-1:0] HALF_R = RXW'(RAMP_TICKS / 2);
	localparam logic [TW-1:0] RAMP_END = TW'(RAMP_TICKS);

	// Item registers
	logic signed [AW-1:0] sp_q, look_q, meas_q, target_q;
	logic signed [SW-1:0] spd_q;
	logic signed [EW-1:0] e_q;
	logic signed [DEW-1:0] de_q;
	logic signed [PW-1:0] prod_q;
	logic signed [OW-1:0] c_q, i_q;
	logic signed [DTW-1:0] dterm_q;
	logic signed [KTW-1:0] kterm_q;
	logic scale_q, ramp_act_q;

	// State kept across items
	logic signed [OW-1:0] acc_q;
	logic signed [AW-1:0] prev_meas_q, prev_sp_q;
	logic [TW-1:0] ramp_timer_q;

	// Output register
	logic out_valid_q;
	logic signed [OW-1:0] drive_q, p_q, i_out_q;
	logic signed [AW-1:0] tu_q;

	logic [GW-1:0] gain;
	logic signed [rpps_pkg::LIM_W-1:0] lim;
	logic signed [DW-1:0] fd, fd_w;
	logic signed [AW-1:0] tgt_c;
	logic signed [EW-1:0] e_c, e0_c, e_abs;
	logic signed [OW-1:0] c_abs;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic mul_en;
	logic [QW-1:0] q_fin;
	logic signed [OW-1:0] q_s, p_fin, drive_fin;
	logic signed [SUMW-1:0] sum_fin;

	assign gain = (cfg.mode == rpps_pkg::MODE_POINT) ? rpps_pkg::POINT_GAIN : cfg.prop_gain;
	assign lim = (cfg.mode == rpps_pkg::MODE_POINT) ? rpps_pkg::POINT_LIMIT
		: rpps_pkg::TRACK_LIMIT;

	// Look-ahead plausibility filter; pointing mode always uses the setpoint.
	always_comb begin
		fd = DW'(look_q) - DW'(sp_q);
		fd_w = fd;
		if (fd > rpps_pkg::FILTER_WRAP)
			fd_w = fd - rpps_pkg::FULL_TURN;
		else if (fd < rpps_pkg::NEG_FILTER_WRAP)
			fd_w = fd + rpps_pkg::FULL_TURN;
		if (cfg.mode == rpps_pkg::MODE_POINT)
			tgt_c = sp_q;
		else if (fd_w > rpps_pkg::FILTER_WIN || fd_w < rpps_pkg::NEG_FILTER_WIN)
			tgt_c = sp_q;
		else
			tgt_c = look_q;
	end

	assign e_c = rpps_pkg::wrap_turn(DW'(target_q) - DW'(meas_q));
	assign e0_c = rpps_pkg::wrap_turn(DW'(target_q) - DW'(prev_meas_q));
	assign e_abs = (e_q < 0) ? -e_q : e_q;
	assign c_abs = (c_q < 0) ? -c_q : c_q;

	// One shared multiplier, its operands chosen by the current step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_en = 1'b0;
		case (cmd.step)
			rpps_pkg::STEP_P: begin
				mul_a = MA'(e_q);
				mul_b = $signed(MB'(gain));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_I: begin
				mul_a = MA'(e_q);
				mul_b = $signed(MB'(cfg.integral_gain));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_CMP: begin
				mul_a = MA'(e_abs);
				mul_b = $signed(MB'(gain));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_D: begin
				mul_a = MA'(de_q);
				mul_b = $signed(MB'(cfg.deriv_gain));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_KT: begin
				mul_a = MA'(spd_q);
				mul_b = MB'(TICK_RATE);
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_K: begin
				mul_a = $signed(prod_q[MA-1:0]);
				mul_b = $signed(MB'(cfg.feedfwd_gain));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_RS: begin
				mul_a = MA'(c_abs);
				mul_b = $signed(MB'(ramp_timer_q));
				mul_en = 1'b1;
			end
			rpps_pkg::STEP_RQ: begin
				mul_a = $signed(MA'(prod_q[RXW-1:0] + HALF_R));
				mul_b = $signed(MB'(RECIP));
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Final assembly: the ramp quotient sits in the bits above RDIV_SH of the last product.
	always_comb begin
		q_fin = prod_q[RSH+QW-1:RSH];
		q_s = $signed(OW'(q_fin));
		if (scale_q)
			p_fin = (c_q < 0) ? -q_s : q_s;
		else
			p_fin = c_q;
		sum_fin = SUMW'(p_fin) + SUMW'(i_q) + SUMW'(dterm_q) + SUMW'(kterm_q);
		if (cfg.mode == rpps_pkg::MODE_POINT)
			drive_fin = p_fin;
		else
			drive_fin = rpps_pkg::sat(PW'(sum_fin), rpps_pkg::TRACK_LIMIT);
	end

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q <= setpoint;
			look_q <= lookahead_target;
			meas_q <= measured;
		end
		if (mul_en)
			prod_q <= mul_p;
		case (cmd.step)
			rpps_pkg::STEP_TGT: begin
				target_q <= tgt_c;
				spd_q <= SW'(sp_q) - SW'(prev_sp_q);
				ramp_act_q <= ramp_timer_q < RAMP_END;
			end
			rpps_pkg::STEP_ERR: begin
				e_q <= e_c;
				de_q <= DEW'(e_c) - DEW'(e0_c);
			end
			rpps_pkg::STEP_I: begin
				c_q <= rpps_pkg::sat(rpps_pkg::rnd_shift(prod_q, rpps_pkg::RND_8), lim);
			end
			rpps_pkg::STEP_CMP: begin
				i_q <= rpps_pkg::sat(PW'(acc_q) + rpps_pkg::rnd_shift(prod_q, rpps_pkg::RND_16),
					rpps_pkg::TRACK_LIMIT);
			end
			rpps_pkg::STEP_D: begin
				scale_q <= ramp_act_q && (prod_q > PW'(rpps_pkg::SOFT_THRESH));
			end
			rpps_pkg::STEP_KT: begin
				dterm_q <= DTW'(rpps_pkg::rnd_shift(prod_q, rpps_pkg::RND_8));
			end
			rpps_pkg::STEP_RS: begin
				kterm_q <= KTW'(rpps_pkg::rnd_shift(prod_q, rpps_pkg::RND_8));
			end
			default: begin
			end
		endcase
		if (cmd.commit) begin
			drive_q <= drive_fin;
			p_q <= p_fin;
			i_out_q <= (cfg.mode == rpps_pkg::MODE_POINT) ? '0 : i_q;
			tu_q <= target_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			prev_meas_q <= '0;
			prev_sp_q <= '0;
			ramp_timer_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step == rpps_pkg::STEP_TGT) begin
				if (ramp_timer_q < RAMP_END)
					ramp_timer_q <= ramp_timer_q + TW'(1);
				if (cfg.mode == rpps_pkg::MODE_TRACK)
					prev_sp_q <= sp_q;
			end
			// The previous measurement is still needed for the error step.
			if (cmd.step == rpps_pkg::STEP_ERR)
				prev_meas_q <= meas_q;
			if (cmd.commit)
				acc_q <= (cfg.mode == rpps_pkg::MODE_POINT) ? '0 : i_q;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign p_term = p_q;
	assign i_term = i_out_q;
	assign target_used = tu_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_timer_q <= RAMP_END)
		else $error("ramp timer ran past its end");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(PW'(acc_q) <= PW'(rpps_pkg::TRACK_LIMIT)) && (PW'(acc_q) >= -PW'(rpps_pkg::TRACK_LIMIT)))
		else $error("integral accumulator outside its clamp");

endmodule

// ----- hdl/roll_position_pid_soft_start_top.sv -----
// Roll position controller with soft start.
// Items arrive on in_ch (setpoint, lookahead_target, measured, 1/256 degree) and
// leave on out_ch (drive, p_term, i_term, target_used), one result per item, both
// with a valid/ready handshake. Gains and mode are written over the APB port,
// registers at byte addresses 0 (mode), 4, 8, 12 and 16; pready is always high.
// An item is worked through a sequencer that drives one shared multiplier for
// eight products in a row. After acceptance it steps through TGT, ERR, P, I, CMP,
// D, KT, K, RS, RQ and FIN, which commits the result to the output register; a new
// item is taken only back in IDLE, as the multiplier steps are the bound on throughput.
// The output register is separate from the sequencer, so the next item is
// accepted while a result is still waiting. If the receiver stalls, the finished
// item waits in its last step until the output register is free, and no further
// item is accepted meanwhile.
// Reset clears the gains, the mode, the integral, the previous samples and the
// soft-start timer; the first result after reset comes with the ramp at its start.
module roll_position_pid_soft_start_top #(
	parameter int TICK_RATE = rpps_pkg::TICK_RATE_DEF,
	parameter int RAMP_TICKS = rpps_pkg::RAMP_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rpps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	rpps_in_if.sink in_ch,
	rpps_out_if.source out_ch
);

	localparam int GW = rpps_pkg::GAIN_W;

	rpps_pkg::cfg_t cfg_q;
	rpps_pkg::cmd_t cmd;
	rpps_pkg::stat_t stat;
	logic [2:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[rpps_pkg::ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				rpps_pkg::REG_MODE: cfg_q.mode <= pwdata[0];
				rpps_pkg::REG_PROP: cfg_q.prop_gain <= pwdata[GW-1:0];
				rpps_pkg::REG_INTEG: cfg_q.integral_gain <= pwdata[GW-1:0];
				rpps_pkg::REG_DERIV: cfg_q.deriv_gain <= pwdata[GW-1:0];
				rpps_pkg::REG_FFWD: cfg_q.feedfwd_gain <= pwdata[GW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rpps_pkg::REG_MODE: prdata = 32'(cfg_q.mode);
			rpps_pkg::REG_PROP: prdata = 32'(cfg_q.prop_gain);
			rpps_pkg::REG_INTEG: prdata = 32'(cfg_q.integral_gain);
			rpps_pkg::REG_DERIV: prdata = 32'(cfg_q.deriv_gain);
			rpps_pkg::REG_FFWD: prdata = 32'(cfg_q.feedfwd_gain);
			default: prdata = '0;
		endcase
	end

	rpps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.stat(stat),
		.cmd(cmd)
	);

	rpps_dp #(
		.TICK_RATE(TICK_RATE),
		.RAMP_TICKS(RAMP_TICKS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.stat(stat),
		.setpoint(in_ch.setpoint),
		.lookahead_target(in_ch.lookahead_target),
		.measured(in_ch.measured),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.drive(out_ch.drive),
		.p_term(out_ch.p_term),
		.i_term(out_ch.i_term),
		.target_used(out_ch.target_used)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int ANG_W = rpps_pkg::ANG_W;
	localparam int OUT_W = rpps_pkg::OUT_W;
	localparam int GAIN_W = rpps_pkg::GAIN_W;
	localparam int TICK_HZ = rpps_pkg::TICK_RATE_DEF;
	localparam int RAMP_LEN = rpps_pkg::RAMP_TICKS_DEF;

	// Angles in 1/256 degree, speeds in 1/256 degree per second.
	localparam longint TURN = 360 * 256;
	localparam longint HALF = 180 * 256;
	localparam longint WRAP_EDGE = 300 * 256;
	localparam longint WINDOW = 10 * 256;
	localparam longint TRACK_LIM = 60 * 256;
	localparam longint POINT_LIM = 30 * 256;
	localparam longint POINT_KP = 5 * 256;
	localparam longint SOFT_KNEE = 10 * 65536;
	localparam int ANG_MAX = 131071;
	localparam int ANG_MIN = -131072;
	localparam int TARGET_ITEMS = 900;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct {
		logic signed [OUT_W-1:0] drive;
		logic signed [OUT_W-1:0] p_term;
		logic signed [OUT_W-1:0] i_term;
		logic signed [ANG_W-1:0] target_used;
	} tick_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [rpps_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rpps_in_if tick_in();
	rpps_out_if tick_out();

	roll_position_pid_soft_start_top #(
		.TICK_RATE(TICK_HZ),
		.RAMP_TICKS(RAMP_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(tick_in),
		.out_ch(tick_out)
	);

	// Controller copy: configuration and state as the block should hold them.
	logic ctl_mode = rpps_pkg::MODE_TRACK;
	logic [GAIN_W-1:0] kp_q88 = '0;
	logic [GAIN_W-1:0] ki_q016 = '0;
	logic [GAIN_W-1:0] kd_q88 = '0;
	logic [GAIN_W-1:0] kf_q88 = '0;
	logic signed [OUT_W-1:0] integ = '0;
	logic signed [ANG_W-1:0] prev_meas = '0;
	logic signed [ANG_W-1:0] prev_sp = '0;
	logic [7:0] ramp_ticks = '0;

	tick_result_t pending_results[$];
	int errors = 0;
	int sent_items = 0;
	int cycle_count = 0;
	int traj_sp = 0;
	bit no_idle = 0;
	int stall_left = 0;

	always #2 clk = ~clk;

	function automatic longint abs_l(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic longint clamp(input longint x, input longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	function automatic longint round_half_away(input longint x, input int n);
		longint m;
		longint r;
		m = abs_l(x);
		r = (m + (longint'(1) << (n - 1))) >> n;
		return (x < 0) ? -r : r;
	endfunction

	function automatic longint wrap_angle(input longint x);
		longint r;
		r = x % TURN;
		if (r < 0)
			r += TURN;
		if (r > HALF)
			r -= TURN;
		return r;
	endfunction

	// Proportional term; during the ramp a large error gets a fraction of it.
	function automatic longint soft_start_p(input longint gain, input longint e,
		input longint lim);
		longint c;
		longint q;
		c = clamp(round_half_away(gain * e, 8), lim);
		if (ramp_ticks < RAMP_LEN) begin
			ramp_ticks++;
			if (gain == 0)
				return 0;
			if (abs_l(e) * gain > SOFT_KNEE) begin
				q = (abs_l(c) * longint'(ramp_ticks) + RAMP_LEN / 2) / RAMP_LEN;
				return (c < 0) ? -q : q;
			end
		end
		return c;
	endfunction

	function automatic tick_result_t predict_command(input longint sp, input longint la,
		input longint ms);
		tick_result_t r;
		longint d;
		longint tgt;
		longint e;
		longint e0;
		longint p;
		longint i;
		longint dt;
		longint kt;
		longint drive;
		if (ctl_mode == rpps_pkg::MODE_TRACK) begin
			d = la - sp;
			if (d > WRAP_EDGE)
				d -= TURN;
			if (d < -WRAP_EDGE)
				d += TURN;
			tgt = (abs_l(d) > WINDOW) ? sp : la;
			e = wrap_angle(tgt - ms);
			e0 = wrap_angle(tgt - longint'(prev_meas));
			p = soft_start_p(longint'(kp_q88), e, TRACK_LIM);
			i = clamp(longint'(integ) + round_half_away(longint'(ki_q016) * e, 16), TRACK_LIM);
			dt = round_half_away(longint'(kd_q88) * (e - e0), 8);
			kt = round_half_away(longint'(kf_q88) * (sp - longint'(prev_sp)) * TICK_HZ, 8);
			drive = clamp(p + i + dt + kt, TRACK_LIM);
			integ = OUT_W'(i);
			prev_sp = ANG_W'(sp);
		end else begin
			e = wrap_angle(sp - ms);
			tgt = sp;
			p = soft_start_p(POINT_KP, e, POINT_LIM);
			i = 0;
			drive = clamp(p, POINT_LIM);
			integ = '0;
		end
		prev_meas = ANG_W'(ms);
		r.drive = OUT_W'(drive);
		r.p_term = OUT_W'(p);
		r.i_term = OUT_W'(i);
		r.target_used = ANG_W'(tgt);
		return r;
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(3, 1);
		if (pick < 93)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic bit field_matches(input string name, input longint want,
		input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 0;
		end
		return 1;
	endfunction

	task automatic send_tick(input int sp, input int la, input int ms);
		int gap;
		logic signed [ANG_W-1:0] s;
		logic signed [ANG_W-1:0] l;
		logic signed [ANG_W-1:0] m;
		s = ANG_W'(sp);
		l = ANG_W'(la);
		m = ANG_W'(ms);
		gap = (no_idle || $urandom_range(1)) ? 0 : idle_length();
		if (gap > 0) begin
			tick_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_in.valid <= 1'b1;
		tick_in.setpoint <= s;
		tick_in.lookahead_target <= l;
		tick_in.measured <= m;
		do @(posedge clk); while (!tick_in.ready);
		pending_results.push_back(predict_command(longint'(s), longint'(l), longint'(m)));
		sent_items++;
	endtask

	task automatic send_random_tick();
		int shape;
		int sgn;
		int sp;
		int la;
		int ms;
		shape = $urandom_range(99);
		sgn = $urandom_range(1) ? 1 : -1;
		if (shape < 60) begin
			// A moving setpoint with a nearby look-ahead and a measurement lagging it.
			traj_sp += int'($urandom_range(160)) - 80;
			if (traj_sp > ANG_MAX)
				traj_sp -= int'(TURN);
			if (traj_sp < ANG_MIN)
				traj_sp += int'(TURN);
			sp = traj_sp;
			la = sp + int'($urandom_range(6400)) - 3200;
			if ($urandom_range(9) == 0)
				la += sgn * int'(TURN);
			ms = sp + int'($urandom_range(4000)) - 2000;
			if ($urandom_range(19) == 0)
				ms = sp + int'($urandom_range(60000)) - 30000;
		end else if (shape < 80) begin
			// Look-ahead window, filter wrap, half turn and soft-start knees.
			sp = int'($urandom_range(262143)) + ANG_MIN;
			case ($urandom_range(2))
				0: la = sp + sgn * (int'(WINDOW) + int'($urandom_range(2)) - 1);
				1: la = sp + sgn * (int'(WRAP_EDGE) + int'($urandom_range(2)) - 1);
				default: la = sp + sgn * (int'(TURN) - int'($urandom_range(2600)));
			endcase
			sgn = $urandom_range(1) ? 1 : -1;
			case ($urandom_range(2))
				0: ms = sp + sgn * (int'(HALF) + int'($urandom_range(2)) - 1);
				1: ms = sp + sgn * (int'(WINDOW) + int'($urandom_range(2)) - 1);
				default: ms = sp + sgn * (512 + int'($urandom_range(2)) - 1);
			endcase
		end else begin
			sp = int'($urandom);
			la = int'($urandom);
			ms = int'($urandom);
		end
		send_tick(sp, la, ms);
	endtask

	// Holds off new items until every result is back.
	task automatic wait_until_drained();
		tick_in.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rpps_pkg::REG_MODE: ctl_mode = value[0];
			rpps_pkg::REG_PROP: kp_q88 = value[GAIN_W-1:0];
			rpps_pkg::REG_INTEG: ki_q016 = value[GAIN_W-1:0];
			rpps_pkg::REG_DERIV: kd_q88 = value[GAIN_W-1:0];
			rpps_pkg::REG_FFWD: kf_q88 = value[GAIN_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Upper bits carry noise; only the low bits of each register count.
	task automatic set_config(input logic mode, input logic [15:0] kp, input logic [15:0] ki,
		input logic [15:0] kd, input logic [15:0] kf);
		wait_until_drained();
		write_reg(rpps_pkg::REG_MODE, {31'($urandom), mode});
		write_reg(rpps_pkg::REG_PROP, {16'($urandom), kp});
		write_reg(rpps_pkg::REG_INTEG, {16'($urandom), ki});
		write_reg(rpps_pkg::REG_DERIV, {16'($urandom), kd});
		write_reg(rpps_pkg::REG_FFWD, {16'($urandom), kf});
	endtask

	task automatic test_directed_tracking();
		set_config(rpps_pkg::MODE_TRACK, 16'h0100, 16'h0800, 16'h0080, 16'h0004);
		send_tick(0, 0, 0);
		// With kp of one, an error of exactly ten degrees sits on the soft-start knee.
		send_tick(0, 0, -2560);
		send_tick(0, 0, -2561);
		send_tick(0, 2560, 0);
		send_tick(0, 2561, 0);
		send_tick(0, -2561, 0);
		send_tick(46080, -45080, 46000);
		send_tick(-46080, 45580, -46080);
		send_tick(0, 76800, 0);
		send_tick(0, 90000, 0);
		send_tick(46080, 46080, 0);
		send_tick(0, 0, 46080);
		send_tick(ANG_MAX, ANG_MAX, ANG_MIN);
		send_tick(ANG_MIN, ANG_MIN, ANG_MAX);
		send_tick(ANG_MIN, ANG_MAX, 0);
		send_tick(ANG_MAX, ANG_MIN, ANG_MAX);
		send_tick(0, 0, ANG_MAX);
	endtask

	task automatic test_directed_pointing();
		set_config(rpps_pkg::MODE_POINT, 16'h0100, 16'h0800, 16'h0080, 16'h0004);
		send_tick(0, 99, -512);
		send_tick(0, 0, -513);
		send_tick(30000, 0, 0);
		send_tick(-46080, 0, 0);
		send_tick(ANG_MAX, 0, ANG_MIN);
		// A zero proportional gain gives no P term even during the ramp.
		set_config(rpps_pkg::MODE_TRACK, 16'h0000, 16'h0100, 16'h0100, 16'h0010);
		send_tick(1000, 1000, 0);
		send_tick(-5000, -5000, 3000);
	endtask

	task automatic test_ramp_random();
		set_config(rpps_pkg::MODE_TRACK, 16'h0300, 16'h0200, 16'h0100, 16'h0020);
		repeat (40) send_random_tick();
		set_config(rpps_pkg::MODE_POINT, 16'h0300, 16'h0200, 16'h0100, 16'h0020);
		repeat (32) send_random_tick();
	endtask

	task automatic test_gain_extremes();
		set_config(rpps_pkg::MODE_TRACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (30) send_random_tick();
		set_config(rpps_pkg::MODE_TRACK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		repeat (20) send_random_tick();
		set_config(rpps_pkg::MODE_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (20) send_random_tick();
	endtask

	task automatic test_back_to_back();
		set_config(rpps_pkg::MODE_TRACK, 16'h0200, 16'h0100, 16'h0080, 16'h0010);
		no_idle = 1;
		repeat (60) send_random_tick();
		wait_until_drained();
		no_idle = 0;
	endtask

	task automatic test_random_settings();
		int style;
		logic mode;
		logic [15:0] g[4];
		while (sent_items < TARGET_ITEMS) begin
			style = $urandom_range(2);
			mode = ($urandom_range(3) == 0) ? rpps_pkg::MODE_POINT : rpps_pkg::MODE_TRACK;
			for (int k = 0; k < 4; k++) begin
				if (style == 0)
					g[k] = (k == 0) ? 16'($urandom_range(16'h0800, 16'h0080)) :
						16'($urandom_range(16'h0400 >> k));
				else if (style == 1)
					g[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				else
					g[k] = 16'($urandom);
			end
			set_config(mode, g[0], g[1], g[2], g[3]);
			// Indexes past the last register must leave the settings alone.
			if ($urandom_range(2) == 0)
				write_reg(3'(rpps_pkg::REG_FFWD + $urandom_range(3, 1)), $urandom);
			repeat ($urandom_range(60, 30)) send_random_tick();
		end
	endtask

	always @(posedge clk) begin : check_results
		tick_result_t want;
		bit ok;
		if (arst_n && tick_out.valid && tick_out.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: drive %0d p %0d i %0d target %0d",
					$time, tick_out.drive, tick_out.p_term, tick_out.i_term,
					tick_out.target_used);
				errors++;
			end else begin
				want = pending_results.pop_front();
				ok = field_matches("drive", want.drive, tick_out.drive) &
					field_matches("p_term", want.p_term, tick_out.p_term) &
					field_matches("i_term", want.i_term, tick_out.i_term) &
					field_matches("target_used", want.target_used, tick_out.target_used);
				if (!ok)
					errors++;
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			tick_out.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(3) == 0) begin
			stall_left <= idle_length() - 1;
			tick_out.ready <= 1'b0;
		end else begin
			tick_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_in.valid = 1'b0;
		tick_in.setpoint = '0;
		tick_in.lookahead_target = '0;
		tick_in.measured = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_tracking();
		test_directed_pointing();
		test_ramp_random();
		test_gain_extremes();
		test_back_to_back();
		test_random_settings();
		wait_until_drained();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/rpps_pkg.sv
hdl/rpps_ifs.sv
hdl/rpps_ctrl.sv
hdl/rpps_dp.sv
hdl/roll_position_pid_soft_start_top.sv
tb/tb.sv
